// ----- sv/hptc_pkg.sv -----
package hptc_pkg;

    localparam int WORD_W     = 64;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = WORD_W / DIGIT_W;

    typedef logic [WORD_W-1:0] t_word;

    localparam logic [1:0] CMD_TEMP  = 2'd0;
    localparam logic [1:0] CMD_PRESS = 2'd1;
    localparam logic [1:0] CMD_HUM   = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

endpackage

// ----- sv/hptc_mul.sv -----
module hptc_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hptc_pkg::t_word   i_a,
    input  hptc_pkg::t_word   i_b,
    output logic              o_done,
    output hptc_pkg::t_word   o_prod
);
    import hptc_pkg::*;

    localparam int CNT_W = $clog2(NUM_DIGITS);

    t_word            r_acc;
    t_word            r_mcand;
    t_word            r_mplier;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    t_word            w_pp;

    // one digit of the multiplier per cycle, low digit first
    assign w_pp = r_mcand * r_mplier[DIGIT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_cnt    <= '0;
                r_acc    <= '0;
                r_mcand  <= i_a;
                r_mplier <= i_b;
            end else if (r_busy) begin
                r_acc    <= r_acc + w_pp;
                r_mcand  <= r_mcand << DIGIT_W;
                r_mplier <= r_mplier >> DIGIT_W;
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_DIGITS-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ----- sv/hptc_div.sv -----
module hptc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hptc_pkg::t_word   i_num,
    input  hptc_pkg::t_word   i_den,
    output logic              o_done,
    output hptc_pkg::t_word   o_quo
);
    import hptc_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    t_word            r_rem;
    t_word            r_dvd;
    t_word            r_dvs;
    t_word            r_quo;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_fin;
    logic             r_done;
    logic [WORD_W:0]  w_trial;
    logic [WORD_W:0]  w_diff;
    logic             w_bit;
    t_word            n_rem;

    // restoring division, one quotient bit per cycle; quotient shifts into r_dvd
    assign w_trial = {r_rem, r_dvd[WORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_bit   = !w_diff[WORD_W];
    assign n_rem   = w_bit ? w_diff[WORD_W-1:0] : w_trial[WORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvd  <= i_num[WORD_W-1] ? (~i_num + 1'b1) : i_num;
                r_dvs  <= i_den[WORD_W-1] ? (~i_den + 1'b1) : i_den;
                r_neg  <= i_num[WORD_W-1] ^ i_den[WORD_W-1];
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[WORD_W-2:0], w_bit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_W-1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (r_fin) begin
                r_quo  <= r_neg ? (~r_dvd + 1'b1) : r_dvd;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- sv/humidity_pressure_temp_compensation_core.sv -----
// Sensor compensation core: turns raw temperature, pressure or humidity words into
// compensated integers using calibration coefficients written over the APB port
// (8-byte registers at 0x00 temperature, 0x08/0x10/0x18 pressure, 0x20 humidity).
// Input channel: i_command/i_raw_reading with i_in_valid, o_in_stall. Output channel:
// o_kind/o_value/o_invalid with o_out_valid, i_out_stall.
// One word is worked on at a time; o_in_stall is high from acceptance until the
// result has been moved into the output register. A shared 64-bit multiplier takes
// one 4-bit digit per cycle and a restoring divider takes one quotient bit per
// cycle; the step count of each formula, and any output stall, set the latency from
// acceptance to o_out_valid.
// Command 3 is accepted and dropped with no result.
// A temperature word updates the stored fine temperature used by later words.
// If the receiver stalls, the result holds in the output register and the next
// word can still be accepted; a further result waits until the register empties.
// Synchronous reset clears coefficients, fine temperature, the state and the busy and valid flags.
module humidity_pressure_temp_compensation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [19:0] i_raw_reading,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [23:0] o_value,
    output logic        o_invalid,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import hptc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_WB    = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [2:0] REG_TEMP   = 3'd0;
    localparam logic [2:0] REG_PLOW   = 3'd1;
    localparam logic [2:0] REG_PMID   = 3'd2;
    localparam logic [2:0] REG_PHIGH  = 3'd3;
    localparam logic [2:0] REG_HUM    = 3'd4;

    // program steps
    localparam logic [4:0] T_AT2  = 5'd0;
    localparam logic [4:0] T_DD   = 5'd1;
    localparam logic [4:0] T_DT3  = 5'd2;
    localparam logic [4:0] T_X5   = 5'd3;
    localparam logic [4:0] P_XX   = 5'd4;
    localparam logic [4:0] P_B6   = 5'd5;
    localparam logic [4:0] P_B5   = 5'd6;
    localparam logic [4:0] P_A3   = 5'd7;
    localparam logic [4:0] P_A2   = 5'd8;
    localparam logic [4:0] P_D1   = 5'd9;
    localparam logic [4:0] P_NUM  = 5'd10;
    localparam logic [4:0] P_DIV  = 5'd11;
    localparam logic [4:0] P_E9   = 5'd12;
    localparam logic [4:0] P_E9S  = 5'd13;
    localparam logic [4:0] P_E8   = 5'd14;
    localparam logic [4:0] P_SUM  = 5'd15;
    localparam logic [4:0] P_OUT  = 5'd16;
    localparam logic [4:0] H_A    = 5'd17;
    localparam logic [4:0] H_B1   = 5'd18;
    localparam logic [4:0] H_B2   = 5'd19;
    localparam logic [4:0] H_B3   = 5'd20;
    localparam logic [4:0] H_B    = 5'd21;
    localparam logic [4:0] H_V    = 5'd22;
    localparam logic [4:0] H_C    = 5'd23;
    localparam logic [4:0] H_D    = 5'd24;

    localparam t_word       P_TF_OFS   = 64'd128000;
    localparam logic [31:0] H_TF_OFS   = 32'd76800;
    localparam t_word       P_ADC_BASE = 64'd1048576;
    localparam t_word       P_SCALE    = 64'd3125;
    localparam t_word       P_ONE47    = 64'd1 << 47;
    localparam t_word       T_MUL5     = 64'd5;
    localparam t_word       T_ROUND    = 64'd128;
    localparam logic [31:0] H_RND_A    = 32'd16384;
    localparam logic [31:0] H_OFS_B2   = 32'd32768;
    localparam logic [31:0] H_OFS_B3   = 32'd2097152;
    localparam logic [31:0] H_RND_B    = 32'd8192;
    localparam logic [31:0] H_MAX      = 32'd419430400;
    localparam t_word       SAT_HI     = 64'd8388607;
    localparam t_word       SAT_LO     = 64'hFFFF_FFFF_FF80_0000;
    localparam t_word       DIV_RND    = 64'd255;

    function automatic t_word sx16(input logic [15:0] v);
        sx16 = {{48{v[15]}}, v};
    endfunction

    function automatic t_word sx32(input logic [31:0] v);
        sx32 = {{32{v[31]}}, v};
    endfunction

    function automatic logic [23:0] sat24(input t_word v);
        if ($signed(v) > $signed(SAT_HI)) begin
            sat24 = SAT_HI[23:0];
        end else if ($signed(v) < $signed(SAT_LO)) begin
            sat24 = SAT_LO[23:0];
        end else begin
            sat24 = v[23:0];
        end
    endfunction

    // configuration
    logic [47:0] r_cfg_t;
    logic [47:0] r_cfg_pl;
    logic [47:0] r_cfg_pm;
    logic [47:0] r_cfg_ph;
    logic [63:0] r_cfg_h;
    logic [2:0]  w_reg_idx;
    logic        w_cfg_wr;

    assign w_reg_idx = paddr[5:3];
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_t  <= '0;
            r_cfg_pl <= '0;
            r_cfg_pm <= '0;
            r_cfg_ph <= '0;
            r_cfg_h  <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_TEMP:  r_cfg_t  <= pwdata[47:0];
                REG_PLOW:  r_cfg_pl <= pwdata[47:0];
                REG_PMID:  r_cfg_pm <= pwdata[47:0];
                REG_PHIGH: r_cfg_ph <= pwdata[47:0];
                REG_HUM:   r_cfg_h  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_TEMP:  prdata = {16'b0, r_cfg_t};
            REG_PLOW:  prdata = {16'b0, r_cfg_pl};
            REG_PMID:  prdata = {16'b0, r_cfg_pm};
            REG_PHIGH: prdata = {16'b0, r_cfg_ph};
            REG_HUM:   prdata = r_cfg_h;
            default:   prdata = '0;
        endcase
    end

    // coefficient fields
    t_word w_t1, w_t2, w_t3;
    t_word w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    t_word w_h1, w_h2, w_h3, w_h5, w_h6;
    logic [11:0] w_h4;

    assign w_t1 = {48'b0, r_cfg_t[15:0]};
    assign w_t2 = sx16(r_cfg_t[31:16]);
    assign w_t3 = sx16(r_cfg_t[47:32]);
    assign w_p1 = {48'b0, r_cfg_pl[15:0]};
    assign w_p2 = sx16(r_cfg_pl[31:16]);
    assign w_p3 = sx16(r_cfg_pl[47:32]);
    assign w_p4 = sx16(r_cfg_pm[15:0]);
    assign w_p5 = sx16(r_cfg_pm[31:16]);
    assign w_p6 = sx16(r_cfg_pm[47:32]);
    assign w_p7 = sx16(r_cfg_ph[15:0]);
    assign w_p8 = sx16(r_cfg_ph[31:16]);
    assign w_p9 = sx16(r_cfg_ph[47:32]);
    assign w_h1 = {56'b0, r_cfg_h[7:0]};
    assign w_h2 = sx16(r_cfg_h[23:8]);
    assign w_h3 = {56'b0, r_cfg_h[31:24]};
    assign w_h4 = r_cfg_h[43:32];
    assign w_h5 = {{52{r_cfg_h[55]}}, r_cfg_h[55:44]};
    assign w_h6 = {{56{r_cfg_h[63]}}, r_cfg_h[63:56]};

    // sequencer
    logic [2:0]  r_state;
    logic [4:0]  r_pc;
    logic [1:0]  r_cmd;
    logic [19:0] r_raw;
    logic [31:0] r_fine;
    t_word       r_a, r_b, r_t, r_m1, r_q;
    logic [23:0] r_res_value;
    logic        r_res_invalid;
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [23:0] r_value;
    logic        r_invalid;

    logic        w_in_acc;
    logic        w_out_free;
    t_word       w_px, w_hx, w_qs;
    t_word       w_opa, w_opb;
    logic        w_mul_start, w_div_start;
    logic        w_mul_done, w_div_done;
    t_word       w_prod, w_quo;
    logic        w_alu_step;
    logic        w_div_zero;
    logic        w_final;
    logic [31:0] w_prod32;
    t_word       w_tf;
    t_word       w_trnd;
    logic [31:0] w_hsum;
    logic [31:0] w_hd;
    logic [31:0] w_hv;
    logic [31:0] w_hclip;
    t_word       w_pp;
    t_word       w_pdiv;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    assign w_px = sx32(r_fine) - P_TF_OFS;
    assign w_hx = sx32(r_fine - H_TF_OFS);
    assign w_qs = t_word'($signed(r_q) >>> 13);
    assign w_prod32 = w_prod[31:0];

    assign w_alu_step = (r_pc == P_SUM) || (r_pc == P_OUT);
    assign w_div_zero = (w_prod[63:33] == '0);
    assign w_final = (r_pc == T_X5) || (r_pc == P_OUT) || (r_pc == H_D)
                     || ((r_pc == P_D1) && w_div_zero);

    assign w_mul_start = (r_state == ST_ISSUE) && !w_alu_step && (r_pc != P_DIV);
    assign w_div_start = (r_state == ST_ISSUE) && (r_pc == P_DIV);

    always_comb begin
        case (r_pc)
            T_AT2: begin
                w_opa = {44'b0, 3'b0, r_raw[19:3]} - (w_t1 << 1);
                w_opb = w_t2;
            end
            T_DD: begin
                w_opa = {48'b0, r_raw[19:4]} - w_t1;
                w_opb = {48'b0, r_raw[19:4]} - w_t1;
            end
            T_DT3: begin w_opa = r_t;  w_opb = w_t3;   end
            T_X5:  begin w_opa = r_a;  w_opb = T_MUL5; end
            P_XX:  begin w_opa = w_px; w_opb = w_px;   end
            P_B6:  begin w_opa = r_m1; w_opb = w_p6;   end
            P_B5:  begin w_opa = w_px; w_opb = w_p5;   end
            P_A3:  begin w_opa = r_m1; w_opb = w_p3;   end
            P_A2:  begin w_opa = w_px; w_opb = w_p2;   end
            P_D1:  begin w_opa = r_a;  w_opb = w_p1;   end
            P_NUM: begin
                w_opa = ((P_ADC_BASE - {44'b0, r_raw}) << 31) - r_b;
                w_opb = P_SCALE;
            end
            P_DIV: begin w_opa = r_m1; w_opb = r_t;    end
            P_E9:  begin w_opa = w_p9; w_opb = w_qs;   end
            P_E9S: begin w_opa = r_a;  w_opb = w_qs;   end
            P_E8:  begin w_opa = w_p8; w_opb = r_q;    end
            H_A:   begin w_opa = w_h5; w_opb = w_hx;   end
            H_B1:  begin w_opa = w_hx; w_opb = w_h6;   end
            H_B2:  begin w_opa = w_hx; w_opb = w_h3;   end
            H_B3:  begin w_opa = r_t;  w_opb = r_b;    end
            H_B:   begin w_opa = r_t;  w_opb = w_h2;   end
            H_V:   begin w_opa = r_a;  w_opb = r_b;    end
            H_C:   begin w_opa = r_t;  w_opb = r_t;    end
            H_D:   begin w_opa = r_t;  w_opb = w_h1;   end
            default: begin w_opa = '0; w_opb = '0;     end
        endcase
    end

    hptc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_opa),
        .i_b     (w_opb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    hptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_opa),
        .i_den   (w_opb),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // writeback helpers
    assign w_tf    = r_a + t_word'($signed(w_prod) >>> 14);
    assign w_trnd  = t_word'($signed(w_prod + T_ROUND) >>> 8);
    assign w_hsum  = {2'b0, r_raw[15:0], 14'b0} - {w_h4, 20'b0} - w_prod32 + H_RND_A;
    assign w_hd    = 32'($signed(w_prod32) >>> 4);
    assign w_hv    = r_a[31:0] - w_hd;
    assign w_hclip = w_hv[31] ? 32'd0 : ((w_hv > H_MAX) ? H_MAX : w_hv);
    assign w_pp    = r_a;
    // divide by 256 toward zero
    assign w_pdiv  = w_pp[63] ? t_word'($signed(w_pp + DIV_RND) >>> 8)
                              : t_word'($signed(w_pp) >>> 8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fine      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the taken word unless a new one loads this cycle
            if (r_out_valid && !i_out_stall && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (i_command != CMD_NONE)) begin
                        r_cmd         <= i_command;
                        r_raw         <= i_raw_reading;
                        r_res_invalid <= 1'b0;
                        unique case (i_command)
                            CMD_TEMP:  r_pc <= T_AT2;
                            CMD_PRESS: r_pc <= P_XX;
                            default:   r_pc <= H_A;
                        endcase
                        r_state <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    r_state <= w_alu_step ? ST_WB : ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_mul_done || w_div_done) begin
                        r_state <= ST_WB;
                    end
                end
                ST_WB: begin
                    case (r_pc)
                        T_AT2: r_a <= t_word'($signed(w_prod) >>> 11);
                        T_DD:  r_t <= t_word'($signed(w_prod) >>> 12);
                        T_DT3: begin
                            r_a    <= w_tf;
                            r_fine <= w_tf[31:0];
                        end
                        T_X5:  r_res_value <= sat24(w_trnd);
                        P_XX:  r_m1 <= w_prod;
                        P_B6:  r_b  <= w_prod;
                        P_B5:  r_b  <= r_b + (w_prod << 17) + (w_p4 << 35);
                        P_A3:  r_a  <= t_word'($signed(w_prod) >>> 8);
                        P_A2:  r_a  <= r_a + (w_prod << 12) + P_ONE47;
                        P_D1: begin
                            r_t <= t_word'($signed(w_prod) >>> 33);
                            if (w_div_zero) begin
                                r_res_value   <= '0;
                                r_res_invalid <= 1'b1;
                            end
                        end
                        P_NUM: r_m1 <= w_prod;
                        P_DIV: r_q  <= w_quo;
                        P_E9:  r_a  <= w_prod;
                        P_E9S: r_a  <= t_word'($signed(w_prod) >>> 25);
                        P_E8:  r_a  <= r_a + t_word'($signed(w_prod) >>> 19) + r_q;
                        P_SUM: r_a  <= t_word'($signed(r_a) >>> 8) + (w_p7 << 4);
                        P_OUT: r_res_value <= sat24(w_pdiv);
                        H_A:   r_a <= t_word'($signed(sx32(w_hsum)) >>> 15);
                        H_B1:  r_t <= t_word'($signed(sx32(w_prod32)) >>> 10);
                        H_B2:  r_b <= t_word'($signed(sx32(w_prod32)) >>> 11)
                                      + sx32(H_OFS_B2);
                        H_B3:  r_t <= sx32(32'($signed(w_prod32) >>> 10) + H_OFS_B3);
                        H_B:   r_b <= sx32(32'($signed(w_prod32 + H_RND_B) >>> 14));
                        H_V: begin
                            r_a <= sx32(w_prod32);
                            r_t <= sx32(32'($signed(w_prod32) >>> 15));
                        end
                        H_C:   r_t <= sx32(32'($signed(w_prod32) >>> 7));
                        H_D:   r_res_value <= {4'b0, w_hclip[31:12]};
                        default: ;
                    endcase
                    if (w_final) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_pc    <= r_pc + 1'b1;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= r_cmd;
                        r_value     <= r_res_value;
                        r_invalid   <= r_res_invalid;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_value     = r_value;
    assign o_invalid   = r_invalid;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_command != CMD_NONE) |=> o_in_stall)
        else $error("core took a word but did not stall input");

    a_invalid_only_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_invalid |-> (o_kind == CMD_PRESS) && (o_value == 24'd0))
        else $error("invalid flag on a non-pressure or nonzero result");

    a_hum_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == CMD_HUM) |-> !o_value[23])
        else $error("negative humidity result");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_start && w_div_start))
        else $error("multiplier and divider started together");
`endif

endmodule

// ----- tb/humidity_pressure_temp_compensation_core_tb.sv -----
`timescale 1ns / 100ps

module humidity_pressure_temp_compensation_core_tb;
    import hptc_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES = 2000;

    typedef struct packed {
        logic [1:0]  command;
        logic [19:0] raw;
    } t_reading;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] value;
        logic        invalid;
    } t_comp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_command;
    logic [19:0] i_raw_reading;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic [23:0] o_value;
    logic        o_invalid;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    humidity_pressure_temp_compensation_core u_top (.*);

    // calibration and state mirrored in the predictor
    logic [47:0] cal_temp;
    logic [47:0] cal_press_lo;
    logic [47:0] cal_press_mid;
    logic [47:0] cal_press_hi;
    logic [63:0] cal_hum;
    logic signed [31:0] t_fine = '0;

    t_reading pending_words[$];
    t_comp    expected_comps[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  feed_done;
    bit  hold_out;
    bit  hold_done;
    int  hold_cnt;
    bit  sender_pause;
    bit  in_acc_q;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic signed [63:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    function automatic logic signed [31:0] w32(input logic signed [63:0] v);
        return v[31:0];
    endfunction

    function automatic t_comp compensate(input t_reading w);
        t_comp r;
        logic signed [63:0] adc, t1, t2, t3, a, d, v1, v2, tf;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, x, b, an, dv, nm, q, e1, e2, p;
        logic signed [63:0] h1, h2, h3, h4, h5, h6, hx, ha, b1, b2, b3, hb, hv, hs, hc, hd;
        r.kind = w.command;
        r.invalid = 1'b0;
        adc = {44'd0, w.raw};
        case (w.command)
            CMD_TEMP: begin
                t1 = {48'd0, cal_temp[15:0]};
                t2 = {{48{cal_temp[31]}}, cal_temp[31:16]};
                t3 = {{48{cal_temp[47]}}, cal_temp[47:32]};
                a = (adc >>> 3) - 2 * t1;
                d = (adc >>> 4) - t1;
                v1 = (a * t2) >>> 11;
                v2 = (((d * d) >>> 12) * t3) >>> 14;
                tf = v1 + v2;
                t_fine = tf[31:0];
                r.value = 24'(sat24((tf * 5 + 128) >>> 8));
            end
            CMD_PRESS: begin
                p1 = {48'd0, cal_press_lo[15:0]};
                p2 = {{48{cal_press_lo[31]}}, cal_press_lo[31:16]};
                p3 = {{48{cal_press_lo[47]}}, cal_press_lo[47:32]};
                p4 = {{48{cal_press_mid[15]}}, cal_press_mid[15:0]};
                p5 = {{48{cal_press_mid[31]}}, cal_press_mid[31:16]};
                p6 = {{48{cal_press_mid[47]}}, cal_press_mid[47:32]};
                p7 = {{48{cal_press_hi[15]}}, cal_press_hi[15:0]};
                p8 = {{48{cal_press_hi[31]}}, cal_press_hi[31:16]};
                p9 = {{48{cal_press_hi[47]}}, cal_press_hi[47:32]};
                x = 64'(t_fine) - 64'sd128000;
                b = x * x * p6;
                b = b + ((x * p5) <<< 17);
                b = b + (p4 <<< 35);
                an = ((x * x * p3) >>> 8) + ((x * p2) <<< 12);
                dv = (((64'sd1 <<< 47) + an) * p1) >>> 33;
                if (dv == 0) begin
                    r.invalid = 1'b1;
                    r.value = '0;
                end else begin
                    nm = (((64'sd1048576 - adc) <<< 31) - b) * 64'sd3125;
                    // most negative over -1 wraps back to itself
                    if (nm == {1'b1, 63'd0} && dv == -64'sd1)
                        q = nm;
                    else
                        q = nm / dv;
                    e1 = (p9 * (q >>> 13) * (q >>> 13)) >>> 25;
                    e2 = (p8 * q) >>> 19;
                    p = ((q + e1 + e2) >>> 8) + (p7 <<< 4);
                    r.value = 24'(sat24(p / 256));
                end
            end
            default: begin
                h1 = {56'd0, cal_hum[7:0]};
                h2 = {{48{cal_hum[23]}}, cal_hum[23:8]};
                h3 = {56'd0, cal_hum[31:24]};
                h4 = {{52{cal_hum[43]}}, cal_hum[43:32]};
                h5 = {{52{cal_hum[55]}}, cal_hum[55:44]};
                h6 = {{56{cal_hum[63]}}, cal_hum[63:56]};
                adc = {48'd0, w.raw[15:0]};
                hx = w32(64'(t_fine) - 64'sd76800);
                ha = w32(adc * 16384 - h4 * 1048576 - h5 * hx + 16384) >>> 15;
                b1 = w32(hx * h6) >>> 10;
                b2 = (w32(hx * h3) >>> 11) + 32768;
                b3 = w32((w32(b1 * b2) >>> 10) + 2097152);
                hb = w32(b3 * h2 + 8192) >>> 14;
                hv = w32(ha * hb);
                hs = hv >>> 15;
                hc = w32(hs * hs) >>> 7;
                hd = w32(hc * h1) >>> 4;
                hv = w32(hv - hd);
                if (hv < 0)
                    hv = 0;
                if (hv > 64'sd419430400)
                    hv = 64'sd419430400;
                r.value = 24'(sat24(hv >>> 12));
            end
        endcase
        return r;
    endfunction

    // note whether the word on the input was taken at the last rising edge
    always @(posedge i_clk) begin
        in_acc_q <= i_in_valid && !o_in_stall;
    end

    // driver: one word per handshake, random gaps
    int gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_command <= '0;
            i_raw_reading <= '0;
            gap = 0;
        end else if (i_in_valid && !in_acc_q) begin
            // hold
        end else begin
            if (gap > 0) begin
                gap = gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() > 0 && !sender_pause) begin
                t_reading w;
                w = pending_words.pop_front();
                i_in_valid <= 1'b1;
                i_command <= w.command;
                i_raw_reading <= w.raw;
                if (w.command != CMD_NONE)
                    expected_comps.push_back(compensate(w));
                gap = ($urandom_range(0, 3) == 0) ?
                    (($urandom_range(0, 15) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4))
                    : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    int sgap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            sgap = 0;
        end else if (hold_out && !hold_done) begin
            // long hold-off, counted here
            i_out_stall <= 1'b1;
            hold_cnt = hold_cnt + 1;
            if (hold_cnt >= HOLD_CYCLES)
                hold_done = 1'b1;
        end else if (sgap > 0) begin
            sgap = sgap - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 5) == 0)
                sgap = ($urandom_range(0, 10) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_out_valid && !i_out_stall) begin
                if (expected_comps.size() == 0) begin
                    $error("unexpected word kind=%0d value=%0d", o_kind, $signed(o_value));
                    errors++;
                end else begin
                    t_comp e;
                    e = expected_comps.pop_front();
                    if (o_kind !== e.kind) begin
                        $error("kind: expected %0d actual %0d", e.kind, o_kind);
                        errors++;
                    end
                    if (o_value !== e.value) begin
                        $error("value: expected %0d actual %0d", $signed(e.value),
                               $signed(o_value));
                        errors++;
                    end
                    if (o_invalid !== e.invalid) begin
                        $error("invalid: expected %0d actual %0d", e.invalid, o_invalid);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic apb_write(input int idx, input logic [63:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 6'(idx * 8);
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            0: cal_temp = data[47:0];
            1: cal_press_lo = data[47:0];
            2: cal_press_mid = data[47:0];
            3: cal_press_hi = data[47:0];
            default: cal_hum = data;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || expected_comps.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_word(input logic [1:0] c, input logic [19:0] r);
        t_reading w;
        w.command = c;
        w.raw = r;
        pending_words.push_back(w);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // typical calibration with mild random spread
    task automatic load_typical();
        logic [15:0] t1, p1;
        t1 = 16'(27504 + $urandom_range(0, 2000) - 1000);
        p1 = 16'(36477 + $urandom_range(0, 2000) - 1000);
        apb_write(0, {16'h0, 16'hFC18, 16'(26435 + $urandom_range(0, 200)), t1});
        apb_write(1, {16'h0, 16'(3024 + $urandom_range(0, 100)), 16'hD4BC, p1});
        apb_write(2, {16'h0, 16'hFFF9, 16'hFF62, 16'h1AF8});
        apb_write(3, {16'h0, 16'd6000, 16'hC5C4, 16'h3A7B});
        apb_write(4, {8'h1E, 12'h032, 12'h148, 8'd0, 16'h0169, 8'h4B});
    endtask

    task automatic run_phase(input int n);
        for (int i = 0; i < n; i++) begin
            int k;
            k = $urandom_range(0, 19);
            if (k == 0)
                push_word(CMD_NONE, 20'($urandom()));
            else if (k < 7)
                push_word(CMD_TEMP, $urandom_range(0, 3) == 0 ? 20'($urandom())
                          : 20'($urandom_range(400000, 600000)));
            else if (k < 13)
                push_word(CMD_PRESS, $urandom_range(0, 3) == 0 ? 20'($urandom())
                          : 20'($urandom_range(250000, 450000)));
            else
                push_word(CMD_HUM, 20'($urandom()));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cal_temp = '0;
        cal_press_lo = '0;
        cal_press_mid = '0;
        cal_press_hi = '0;
        cal_hum = '0;
        hold_out = 1'b0;
        sender_pause = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all-zero calibration: zero divisor
        push_word(CMD_PRESS, 20'd0);
        push_word(CMD_HUM, 20'hFFFFF);
        push_word(CMD_TEMP, 20'hFFFFF);
        push_word(CMD_NONE, 20'h12345);
        wait_idle();

        load_typical();
        push_word(CMD_TEMP, 20'd519888);
        push_word(CMD_PRESS, 20'd415148);
        push_word(CMD_HUM, 20'd30000);
        push_word(CMD_TEMP, 20'd0);
        push_word(CMD_PRESS, 20'hFFFFF);
        push_word(CMD_HUM, 20'd0);
        push_word(CMD_TEMP, 20'hFFFFF);
        push_word(CMD_PRESS, 20'd0);
        push_word(CMD_HUM, 20'hFFFFF);
        push_word(CMD_NONE, 20'hFFFFF);
        wait_idle();

        // extremes of every coefficient
        apb_write(0, 64'hFFFF_8000_7FFF_FFFF);
        apb_write(1, 64'h0000_7FFF_8000_FFFF);
        apb_write(2, 64'h0000_8000_7FFF_8000);
        apb_write(3, 64'h0000_7FFF_8000_7FFF);
        apb_write(4, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(CMD_TEMP, 20'hFFFFF);
        push_word(CMD_PRESS, 20'd1);
        push_word(CMD_HUM, 20'h0FFFF);
        push_word(CMD_TEMP, 20'd0);
        push_word(CMD_PRESS, 20'hFFFFF);
        push_word(CMD_HUM, 20'h08000);
        wait_idle();

        // back-pressure: receiver holds off while the sender keeps offering
        load_typical();
        hold_out = 1'b1;
        run_phase(20);
        while (!hold_done) @(posedge i_clk);
        hold_out = 1'b0;
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 3 == 2) begin
                for (int r = 0; r < 5; r++)
                    apb_write(r, rnd64());
            end else begin
                load_typical();
            end
            run_phase(230);
            // pause the sender until every result has drained
            while (pending_words.size() > 60) @(posedge i_clk);
            sender_pause = 1'b1;
            while (expected_comps.size() > 0) @(posedge i_clk);
            sender_pause = 1'b0;
            wait_idle();
        end
        apb_write(0, 64'd0);
        apb_write(4, 64'd0);
        run_phase(80);
        wait_idle();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
